FILE: rtl/fsdl_pkg.sv
// Package with the shared constants, types and codes of the fair-share debt limiter.
`default_nettype none
package fsdl_pkg;

  // Slot table geometry.
  localparam int MAX_SLOTS        = 16;
  localparam int SLOT_W           = $clog2(MAX_SLOTS);
  localparam int CNT_W            = $clog2(MAX_SLOTS + 1);
  localparam int DEBT_W           = 32;

  // Field and register widths.
  localparam int KIND_W           = 2;
  localparam int BYTES_W          = 12;
  localparam int MS_W             = 16;
  localparam int RATE_W           = 24;
  localparam int CEIL_W           = 28;
  localparam int BUDGET_W         = 40;
  localparam int CFG_IDX_W        = 1;
  localparam int CFG_DATA_W       = 28;

  // Limits of the repayment scheme.
  localparam int MAX_PACKET_BYTES = 2800;
  localparam int REPAY_ROUNDS     = 4;
  localparam int ROUND_W          = $clog2(REPAY_ROUNDS + 1);
  localparam int ONE_BYTE         = 256;
  localparam int FRAC_BITS        = 8;

  // Budget is rate * ms * 1024 / 1000.
  localparam int MS_SCALE_SHIFT   = 10;
  localparam int MS_SCALE_DIV     = 1000;
  localparam int PROD_W           = RATE_W + MS_W;

  // Shared divider geometry, two quotient bits per cycle.
  localparam int DIV_N_W          = PROD_W + MS_SCALE_SHIFT;
  localparam int DIV_D_W          = 10;
  localparam int DIV_STEPS        = DIV_N_W / 2;
  localparam int DIV_CNT_W        = $clog2(DIV_STEPS);

  // Reset values of the registers.
  localparam logic [RATE_W-1:0] RATE_RESET = RATE_W'(256);
  localparam logic [CEIL_W-1:0] CEIL_RESET = CEIL_W'(4096000);

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_RATE_LIMIT   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_DEBT_CEILING = 1'b1;

  // Item kinds.
  localparam logic [KIND_W-1:0] KIND_TICK   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_CHARGE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd2;

  // Control sequencer states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RMW,
    ST_MUL,
    ST_BGO,
    ST_BWAIT,
    ST_RCHK,
    ST_SGO,
    ST_SWAIT,
    ST_SWEEP,
    ST_FRD,
    ST_FOUT
  } state_t;

  // Request to the shared divider.
  typedef struct packed {
    logic                start;
    logic [DIV_N_W-1:0]  dividend;
    logic [DIV_D_W-1:0]  divisor;
  } div_req_t;

endpackage
`default_nettype wire

FILE: rtl/fair_share_debt_limiter.sv
// Top level of the fair-share debt limiter: sequencer, debt table and repayment logic.
//
// An item is taken when start is high and busy is low; exactly one result
// follows, shown for one cycle with out_valid, and the receiver cannot stall
// it. A charge, clear or unused kind reads the debt table, then writes the
// update and loads the result. A tick computes the budget (one multiply, then
// the shared divider), then runs up to four rounds of a share division and a
// sweep of the 16 slots through the table's single read port, then a final
// read of the addressed slot. The debt table needs no clearing pass: one
// valid flag per slot makes an unwritten or cleared slot read as zero.
`default_nettype none
module fair_share_debt_limiter (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  // Command channel.
  input  wire logic                              start,
  output logic                                   busy,
  input  wire logic [fsdl_pkg::KIND_W-1:0]       in_kind,
  input  wire logic [fsdl_pkg::SLOT_W-1:0]       in_slot,
  input  wire logic [fsdl_pkg::BYTES_W-1:0]      in_byte_count,
  input  wire logic [fsdl_pkg::MS_W-1:0]         in_elapsed_ms,
  // Result channel.
  output logic                                   out_valid,
  output logic                                   out_blocked,
  output logic      [fsdl_pkg::DEBT_W-1:0]       out_slot_debt,
  output logic      [fsdl_pkg::BUDGET_W-1:0]     out_budget_left,
  output logic      [fsdl_pkg::CNT_W-1:0]        out_slots_in_debt,
  // Configuration port.
  input  wire logic                              cfg_we,
  input  wire logic [fsdl_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [fsdl_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  localparam int SW = fsdl_pkg::SLOT_W;
  localparam int DW = fsdl_pkg::DEBT_W;
  localparam int BW = fsdl_pkg::BUDGET_W;
  localparam int CW = fsdl_pkg::CNT_W;

  fsdl_pkg::state_t state_r, state_nxt;

  // Configuration registers.
  logic [fsdl_pkg::RATE_W-1:0] rate_r;
  logic [fsdl_pkg::CEIL_W-1:0] ceil_r;

  // Latched item.
  logic [fsdl_pkg::KIND_W-1:0]  kind_r;
  logic [SW-1:0]                slot_r;
  logic [fsdl_pkg::BYTES_W-1:0] bytes_r;
  logic [fsdl_pkg::MS_W-1:0]    ms_r;

  // Tick working registers.
  logic [fsdl_pkg::PROD_W-1:0]  prod_r;
  logic [BW-1:0]                budget_r, budget_nxt;
  logic [BW-1:0]                share_r;
  logic [fsdl_pkg::ROUND_W-1:0] round_r, round_nxt;
  logic [SW-1:0]                idx_r, idx_nxt;

  // Slot bookkeeping.
  logic [fsdl_pkg::MAX_SLOTS-1:0] valid_r;
  logic                           rvalid_r;
  logic [CW-1:0]                  cnt_r, cnt_nxt;

  // Result registers.
  logic          out_valid_r;
  logic          out_blocked_r;
  logic [DW-1:0] out_debt_r;
  logic [BW-1:0] out_budget_r;
  logic [CW-1:0] out_cnt_r;

  // Memory and divider connections.
  logic           mem_we, mem_re;
  logic [SW-1:0]  mem_waddr, mem_raddr;
  logic [DW-1:0]  mem_wdata, mem_q;
  logic [DW-1:0]  debt_cur;
  logic           clr_slot;
  logic           out_load;
  logic           blocked_c;
  fsdl_pkg::div_req_t        div_req;
  logic                      div_done;
  logic [fsdl_pkg::DIV_N_W-1:0] div_q;

  // Charge arithmetic.
  logic [fsdl_pkg::BYTES_W-1:0] bytes_clamped;
  logic [DW:0]                  charge_sum;
  logic [DW-1:0]                charged;

  fsdl_ram u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_q)
  );

  fsdl_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .done  (div_done),
    .quot  (div_q)
  );

  // A slot never written since reset or clear reads as zero.
  assign debt_cur = rvalid_r ? mem_q : '0;

  // Charge: clamp the packet, add it in fixed point and saturate.
  always_comb begin
    bytes_clamped = (bytes_r > fsdl_pkg::BYTES_W'(fsdl_pkg::MAX_PACKET_BYTES)) ?
                    fsdl_pkg::BYTES_W'(fsdl_pkg::MAX_PACKET_BYTES) : bytes_r;
    charge_sum = {1'b0, debt_cur} +
                 (DW + 1)'({bytes_clamped, {fsdl_pkg::FRAC_BITS{1'b0}}});
    charged    = charge_sum[DW] ? {DW{1'b1}} : charge_sum[DW-1:0];
    blocked_c  = (kind_r == fsdl_pkg::KIND_CHARGE) &&
                 (debt_cur > DW'(ceil_r));
  end

  // Sequencer: next state, memory access, divider requests and bookkeeping.
  always_comb begin
    state_nxt  = state_r;
    budget_nxt = budget_r;
    round_nxt  = round_r;
    idx_nxt    = idx_r;
    cnt_nxt    = cnt_r;
    mem_we     = 1'b0;
    mem_waddr  = idx_r;
    mem_wdata  = '0;
    mem_re     = 1'b0;
    mem_raddr  = slot_r;
    clr_slot   = 1'b0;
    out_load   = 1'b0;
    div_req    = '0;
    case (state_r)
      fsdl_pkg::ST_IDLE: begin
        if (start) begin
          if (in_kind == fsdl_pkg::KIND_TICK) begin
            state_nxt = fsdl_pkg::ST_MUL;
          end else begin
            mem_re    = 1'b1;
            mem_raddr = in_slot;
            state_nxt = fsdl_pkg::ST_RMW;
          end
        end
      end
      fsdl_pkg::ST_RMW: begin
        // Charge, clear or no change on the addressed slot.
        mem_waddr = slot_r;
        if (kind_r == fsdl_pkg::KIND_CHARGE && !blocked_c) begin
          mem_we    = 1'b1;
          mem_wdata = charged;
          cnt_nxt   = cnt_r - CW'(debt_cur != '0) + CW'(charged != '0);
        end else if (kind_r == fsdl_pkg::KIND_CLEAR) begin
          clr_slot  = 1'b1;
          cnt_nxt   = cnt_r - CW'(debt_cur != '0);
        end
        out_load  = 1'b1;
        state_nxt = fsdl_pkg::ST_IDLE;
      end
      fsdl_pkg::ST_MUL: begin
        state_nxt = fsdl_pkg::ST_BGO;
      end
      fsdl_pkg::ST_BGO: begin
        div_req.start    = 1'b1;
        div_req.dividend = {prod_r, {fsdl_pkg::MS_SCALE_SHIFT{1'b0}}};
        div_req.divisor  = fsdl_pkg::DIV_D_W'(fsdl_pkg::MS_SCALE_DIV);
        state_nxt        = fsdl_pkg::ST_BWAIT;
      end
      fsdl_pkg::ST_BWAIT: begin
        if (div_done) begin
          budget_nxt = (div_q[fsdl_pkg::DIV_N_W-1:BW] != '0) ? {BW{1'b1}} : div_q[BW-1:0];
          round_nxt  = '0;
          state_nxt  = fsdl_pkg::ST_RCHK;
        end
      end
      fsdl_pkg::ST_RCHK: begin
        // With no slot in debt the remaining rounds change nothing.
        if (round_r != fsdl_pkg::ROUND_W'(fsdl_pkg::REPAY_ROUNDS) &&
            budget_r > BW'(fsdl_pkg::ONE_BYTE) && cnt_r != '0) begin
          state_nxt = fsdl_pkg::ST_SGO;
        end else begin
          state_nxt = fsdl_pkg::ST_FRD;
        end
      end
      fsdl_pkg::ST_SGO: begin
        div_req.start    = 1'b1;
        div_req.dividend = fsdl_pkg::DIV_N_W'(budget_r);
        div_req.divisor  = fsdl_pkg::DIV_D_W'(cnt_r);
        state_nxt        = fsdl_pkg::ST_SWAIT;
      end
      fsdl_pkg::ST_SWAIT: begin
        if (div_done) begin
          idx_nxt   = '0;
          mem_re    = 1'b1;
          mem_raddr = '0;
          state_nxt = fsdl_pkg::ST_SWEEP;
        end
      end
      fsdl_pkg::ST_SWEEP: begin
        // Pay slot idx_r while the next slot is read.
        mem_we    = 1'b1;
        mem_waddr = idx_r;
        if (DW'(debt_cur) > share_r) begin
          mem_wdata  = DW'(debt_cur - DW'(share_r));
          budget_nxt = budget_r - share_r;
        end else begin
          mem_wdata  = '0;
          budget_nxt = budget_r - BW'(debt_cur);
        end
        cnt_nxt = cnt_r - CW'(debt_cur != '0) + CW'(mem_wdata != '0);
        if (idx_r == SW'(fsdl_pkg::MAX_SLOTS - 1)) begin
          round_nxt = round_r + 1'b1;
          state_nxt = fsdl_pkg::ST_RCHK;
        end else begin
          idx_nxt   = idx_r + 1'b1;
          mem_re    = 1'b1;
          mem_raddr = idx_r + 1'b1;
        end
      end
      fsdl_pkg::ST_FRD: begin
        mem_re    = 1'b1;
        mem_raddr = slot_r;
        state_nxt = fsdl_pkg::ST_FOUT;
      end
      fsdl_pkg::ST_FOUT: begin
        out_load  = 1'b1;
        state_nxt = fsdl_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = fsdl_pkg::ST_IDLE;
      end
    endcase
  end

  // State and control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= fsdl_pkg::ST_IDLE;
      valid_r     <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      rate_r      <= fsdl_pkg::RATE_RESET;
      ceil_r      <= fsdl_pkg::CEIL_RESET;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_load;
      if (mem_we) begin
        valid_r[mem_waddr] <= 1'b1;
      end else if (clr_slot) begin
        valid_r[slot_r] <= 1'b0;
      end
      if (cfg_we) begin
        case (cfg_index)
          fsdl_pkg::CFG_RATE_LIMIT:   rate_r <= cfg_wdata[fsdl_pkg::RATE_W-1:0];
          fsdl_pkg::CFG_DEBT_CEILING: ceil_r <= cfg_wdata[fsdl_pkg::CEIL_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (state_r == fsdl_pkg::ST_IDLE && start) begin
      kind_r  <= in_kind;
      slot_r  <= in_slot;
      bytes_r <= in_byte_count;
      ms_r    <= in_elapsed_ms;
    end
    if (state_r == fsdl_pkg::ST_MUL) begin
      prod_r <= rate_r * ms_r;
    end
    if (state_r == fsdl_pkg::ST_SWAIT && div_done) begin
      share_r <= div_q[BW-1:0];
    end
    if (mem_re) begin
      rvalid_r <= valid_r[mem_raddr] && !(mem_we && mem_waddr == mem_raddr);
    end
    budget_r <= budget_nxt;
    round_r  <= round_nxt;
    idx_r    <= idx_nxt;
  end

  // Result registers, loaded in the cycle that finishes an item.
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_blocked_r <= blocked_c;
      out_cnt_r     <= cnt_nxt;
      if (state_r == fsdl_pkg::ST_RMW) begin
        out_budget_r <= '0;
        if (kind_r == fsdl_pkg::KIND_CHARGE && !blocked_c) begin
          out_debt_r <= charged;
        end else if (kind_r == fsdl_pkg::KIND_CLEAR) begin
          out_debt_r <= '0;
        end else begin
          out_debt_r <= debt_cur;
        end
      end else begin
        out_budget_r <= budget_r;
        out_debt_r   <= debt_cur;
      end
    end
  end

  assign busy              = (state_r != fsdl_pkg::ST_IDLE);
  assign out_valid         = out_valid_r;
  assign out_blocked       = out_blocked_r;
  assign out_slot_debt     = out_debt_r;
  assign out_budget_left   = out_budget_r;
  assign out_slots_in_debt = out_cnt_r;

`ifndef ASSERT_OFF
  // A result comes only from the cycle that finishes an item.
  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ($past(state_r) == fsdl_pkg::ST_RMW || $past(state_r) == fsdl_pkg::ST_FOUT))
    else $error("result without a finishing step");

  // The debt count never exceeds the number of slots.
  a_cnt_max: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(fsdl_pkg::MAX_SLOTS))
    else $error("slot count out of range");

  // The table is written only by an update or a repayment sweep.
  a_we_src: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (state_r == fsdl_pkg::ST_RMW || state_r == fsdl_pkg::ST_SWEEP))
    else $error("table write outside an update");

  // A refused charge never carries a budget.
  a_blk_bud: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_blocked_r) |-> (out_budget_r == '0))
    else $error("refused charge with a budget");
`endif

endmodule
`default_nettype wire

FILE: rtl/fsdl_ram.sv
// Debt table memory: one write port and one read port with registered read data.
`default_nettype none
module fsdl_ram (
  input  wire logic                          clk,
  input  wire logic                          we,
  input  wire logic [fsdl_pkg::SLOT_W-1:0]   waddr,
  input  wire logic [fsdl_pkg::DEBT_W-1:0]   wdata,
  input  wire logic                          re,
  input  wire logic [fsdl_pkg::SLOT_W-1:0]   raddr,
  output logic      [fsdl_pkg::DEBT_W-1:0]   rdata
);

  logic [fsdl_pkg::DEBT_W-1:0] mem [fsdl_pkg::MAX_SLOTS];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port with registered read data.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

FILE: rtl/fsdl_div.sv
// Iterative unsigned divider that retires two quotient bits per cycle.
`default_nettype none
module fsdl_div (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire fsdl_pkg::div_req_t             req,
  output logic                                done,
  output logic      [fsdl_pkg::DIV_N_W-1:0]   quot
);

  localparam int NW = fsdl_pkg::DIV_N_W;
  localparam int DW = fsdl_pkg::DIV_D_W;

  logic                           busy_r;
  logic                           done_r;
  logic [fsdl_pkg::DIV_CNT_W-1:0] cnt_r;
  logic [NW-1:0]                  quo_r;
  logic [DW-1:0]                  rem_r;
  logic [DW-1:0]                  dvs_r;
  logic [DW:0]                    t1;
  logic [DW:0]                    t2;
  logic [DW-1:0]                  r1;
  logic [DW-1:0]                  r2;
  logic                           b1;
  logic                           b2;

  // Two restoring steps per cycle.
  always_comb begin
    t1 = {rem_r, quo_r[NW-1]};
    b1 = (t1 >= {1'b0, dvs_r});
    r1 = b1 ? DW'(t1 - {1'b0, dvs_r}) : t1[DW-1:0];
    t2 = {r1, quo_r[NW-2]};
    b2 = (t2 >= {1'b0, dvs_r});
    r2 = b2 ? DW'(t2 - {1'b0, dvs_r}) : t2[DW-1:0];
  end

  // Control of the iteration.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == fsdl_pkg::DIV_CNT_W'(fsdl_pkg::DIV_STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Datapath: the dividend shifts out as the quotient shifts in.
  always_ff @(posedge clk) begin
    if (req.start) begin
      quo_r <= req.dividend;
      rem_r <= '0;
      dvs_r <= req.divisor;
    end else if (busy_r) begin
      quo_r <= {quo_r[NW-3:0], b1, b2};
      rem_r <= r2;
    end
  end

  assign done = done_r;
  assign quot = quo_r;

endmodule
`default_nettype wire

FILE: dv/tb_fair_share_debt_limiter.sv
// Self-checking testbench for the fair-share debt limiter, with a driver, a monitor and a debt-table predictor.
`timescale 1ns / 100ps
`default_nettype none
module tb_fair_share_debt_limiter;
  import fsdl_pkg::*;

  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
  localparam int RANDOM_PER_PHASE = 290;
  localparam int CYCLE_LIMIT = 2000000;
  localparam logic [63:0] BUDGET_CAP = 64'hFF_FFFF_FFFF;
  localparam logic [63:0] DEBT_CAP = 64'hFFFF_FFFF;

  typedef struct {
    logic [KIND_W-1:0]  kind;
    logic [SLOT_W-1:0]  slot;
    logic [BYTES_W-1:0] byte_count;
    logic [MS_W-1:0]    elapsed_ms;
  } command_t;

  typedef struct {
    logic                blocked;
    logic [DEBT_W-1:0]   slot_debt;
    logic [BUDGET_W-1:0] budget_left;
    logic [CNT_W-1:0]    slots_in_debt;
  } outcome_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [KIND_W-1:0] in_kind = '0;
  logic [SLOT_W-1:0] in_slot = '0;
  logic [BYTES_W-1:0] in_byte_count = '0;
  logic [MS_W-1:0] in_elapsed_ms = '0;
  logic out_valid;
  logic out_blocked;
  logic [DEBT_W-1:0] out_slot_debt;
  logic [BUDGET_W-1:0] out_budget_left;
  logic [CNT_W-1:0] out_slots_in_debt;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  // Predictor state: the debt per slot and the two registers.
  logic [DEBT_W-1:0] debt_model [MAX_SLOTS];
  logic [RATE_W-1:0] rate_model = RATE_RESET;
  logic [CEIL_W-1:0] ceiling_model = CEIL_RESET;

  command_t pending_cmds[$];
  outcome_t owed_results[$];
  command_t cur_cmd;
  int gap_left = 0;
  bit no_idle = 1'b0;
  bit failed = 1'b0;
  int unsigned cycles = 0;

  fair_share_debt_limiter u_top (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_kind(in_kind), .in_slot(in_slot), .in_byte_count(in_byte_count),
    .in_elapsed_ms(in_elapsed_ms), .out_valid(out_valid), .out_blocked(out_blocked),
    .out_slot_debt(out_slot_debt), .out_budget_left(out_budget_left),
    .out_slots_in_debt(out_slots_in_debt), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  always #5 clk = ~clk;

  function automatic int count_owing();
    int n;
    n = 0;
    for (int k = 0; k < MAX_SLOTS; k++) if (debt_model[k] != 0) n++;
    return n;
  endfunction

  // Applies one accepted command to the debt table and returns the outcome.
  function automatic outcome_t apply_command(command_t c);
    outcome_t r;
    logic [63:0] budget;
    logic [63:0] share;
    logic [63:0] debt;
    logic [BYTES_W-1:0] bytes;
    int n;
    r.blocked = 1'b0;
    budget = 64'd0;
    if (c.kind == KIND_TICK) begin
      budget = (64'(rate_model) * 64'(c.elapsed_ms) * 64'd1024) / 64'd1000;
      if (budget > BUDGET_CAP) budget = BUDGET_CAP;
      // Equal-share rounds, each share capped at the slot's debt.
      for (int rnd = 0; rnd < REPAY_ROUNDS && budget > ONE_BYTE; rnd++) begin
        n = count_owing();
        if (n != 0) begin
          share = budget / n;
          for (int k = 0; k < MAX_SLOTS; k++) begin
            debt = 64'(debt_model[k]);
            if (debt > share) begin
              budget -= share;
              debt_model[k] = DEBT_W'(debt - share);
            end else begin
              budget -= debt;
              debt_model[k] = '0;
            end
          end
        end
      end
    end else if (c.kind == KIND_CHARGE) begin
      debt = 64'(debt_model[c.slot]);
      if (debt > 64'(ceiling_model)) begin
        r.blocked = 1'b1;
      end else begin
        bytes = (c.byte_count > MAX_PACKET_BYTES) ? BYTES_W'(MAX_PACKET_BYTES) : c.byte_count;
        debt += 64'(bytes) << FRAC_BITS;
        if (debt > DEBT_CAP) debt = DEBT_CAP;
        debt_model[c.slot] = DEBT_W'(debt);
      end
    end else if (c.kind == KIND_CLEAR) begin
      debt_model[c.slot] = '0;
    end
    r.slot_debt = debt_model[c.slot];
    r.budget_left = BUDGET_W'(budget);
    n = count_owing();
    r.slots_in_debt = CNT_W'((n > 31) ? 31 : n);
    return r;
  endfunction

  // Driver: holds each command until its transfer, then waits a random gap (none while no_idle is set).
  always @(posedge clk) begin
    if (rst_n) begin
      if (start && !busy) owed_results.push_back(apply_command(cur_cmd));
      if (!(start && busy)) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          start <= 1'b0;
        end else if (pending_cmds.size() > 0) begin
          cur_cmd = pending_cmds.pop_front();
          in_kind <= cur_cmd.kind;
          in_slot <= cur_cmd.slot;
          in_byte_count <= cur_cmd.byte_count;
          in_elapsed_ms <= cur_cmd.elapsed_ms;
          start <= 1'b1;
          gap_left <= no_idle ? 0 : $urandom_range(0, 10);
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: every result strobe is checked against the oldest expectation.
  always @(posedge clk) begin
    outcome_t e;
    if (rst_n && out_valid) begin
      if (owed_results.size() == 0) begin
        $display("%0t: unexpected result blocked=%0d debt=%h budget=%h count=%0d", $time,
                 out_blocked, out_slot_debt, out_budget_left, out_slots_in_debt);
        failed = 1'b1;
      end else begin
        e = owed_results.pop_front();
        if (out_blocked !== e.blocked) begin
          $display("%0t: blocked expected %0d actual %0d", $time, e.blocked, out_blocked);
          failed = 1'b1;
        end
        if (out_slot_debt !== e.slot_debt) begin
          $display("%0t: slot_debt expected %h actual %h", $time, e.slot_debt, out_slot_debt);
          failed = 1'b1;
        end
        if (out_budget_left !== e.budget_left) begin
          $display("%0t: budget_left expected %h actual %h", $time, e.budget_left,
                   out_budget_left);
          failed = 1'b1;
        end
        if (out_slots_in_debt !== e.slots_in_debt) begin
          $display("%0t: slots_in_debt expected %0d actual %0d", $time, e.slots_in_debt,
                   out_slots_in_debt);
          failed = 1'b1;
        end
      end
    end
  end

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_fair_share_debt_limiter failed");
      $finish;
    end
  end

  task automatic queue_cmd(logic [KIND_W-1:0] kind, int slot, int bytes, int ms);
    command_t c;
    c.kind = kind;
    c.slot = SLOT_W'(slot);
    c.byte_count = BYTES_W'(bytes);
    c.elapsed_ms = MS_W'(ms);
    pending_cmds.push_back(c);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int unsigned value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= CFG_DATA_W'(value);
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_RATE_LIMIT) rate_model = RATE_W'(value);
    else ceiling_model = CEIL_W'(value);
  endtask

  // Random commands, mostly charges and ticks on a handful of busy slots.
  task automatic queue_random(int count);
    int sel;
    int slot;
    int bytes;
    int ms;
    for (int i = 0; i < count; i++) begin
      sel = $urandom_range(0, 99);
      slot = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : $urandom_range(0, 4);
      bytes = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 4095) : $urandom_range(40, 1500);
      ms = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, 300);
      if (sel < 55) queue_cmd(KIND_CHARGE, slot, bytes, $urandom_range(0, 65535));
      else if (sel < 85) queue_cmd(KIND_TICK, $urandom_range(0, 15), $urandom_range(0, 4095), ms);
      else if (sel < 95) queue_cmd(KIND_CLEAR, slot, $urandom_range(0, 4095),
                                   $urandom_range(0, 65535));
      else queue_cmd(KIND_UNUSED, $urandom_range(0, 15), $urandom_range(0, 4095),
                     $urandom_range(0, 65535));
    end
  endtask

  // Lets every queued command finish and the block settle before the next phase.
  task automatic drain();
    wait (pending_cmds.size() == 0 && !start && owed_results.size() == 0);
    repeat (20) @(posedge clk);
  endtask

  initial begin
    for (int k = 0; k < MAX_SLOTS; k++) debt_model[k] = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Reset settings: empty table, packet size extremes, unused kind and ceiling refusal.
    queue_cmd(KIND_TICK, 0, 0, 100);
    queue_cmd(KIND_CHARGE, 0, 0, 0);
    queue_cmd(KIND_CHARGE, 15, 4095, 65535);
    queue_cmd(KIND_CHARGE, 1, 2800, 0);
    queue_cmd(KIND_CHARGE, 2, 2801, 0);
    queue_cmd(KIND_UNUSED, 15, 4095, 65535);
    for (int i = 0; i < 8; i++) queue_cmd(KIND_CHARGE, 3, 2800, 0);
    queue_cmd(KIND_TICK, 0, 0, 0);
    queue_cmd(KIND_TICK, 15, 4095, 65535);
    queue_cmd(KIND_CLEAR, 15, 0, 0);
    queue_cmd(KIND_CLEAR, 0, 4095, 65535);
    queue_random(RANDOM_PER_PHASE);
    drain();

    // Smallest rate and ceiling: almost every charge to a slot that already owes is refused.
    write_reg(CFG_RATE_LIMIT, 1);
    write_reg(CFG_DEBT_CEILING, 2);
    queue_cmd(KIND_CHARGE, 4, 0, 0);
    queue_cmd(KIND_CHARGE, 4, 1, 0);
    queue_cmd(KIND_CHARGE, 4, 1, 0);
    queue_cmd(KIND_TICK, 0, 0, 1);
    queue_cmd(KIND_TICK, 0, 0, 65535);
    queue_random(RANDOM_PER_PHASE);
    drain();

    // Largest rate and ceiling: the tick budget saturates.
    write_reg(CFG_RATE_LIMIT, 24'hFF_FFFF);
    write_reg(CFG_DEBT_CEILING, 28'hFFF_FFFF);
    no_idle = 1'b1;
    for (int k = 0; k < MAX_SLOTS; k++) queue_cmd(KIND_CHARGE, k, 2800, 0);
    queue_cmd(KIND_TICK, 0, 0, 65535);
    queue_random(RANDOM_PER_PHASE);
    drain();
    no_idle = 1'b0;

    // Moderate rate with a low ceiling, so that debts pile up across several rounds.
    write_reg(CFG_RATE_LIMIT, $urandom_range(64, 4096));
    write_reg(CFG_DEBT_CEILING, $urandom_range(2, 1 << 22));
    queue_random(RANDOM_PER_PHASE);
    drain();

    // Fully random settings.
    write_reg(CFG_RATE_LIMIT, $urandom_range(1, 24'hFF_FFFF));
    write_reg(CFG_DEBT_CEILING, $urandom_range(2, 28'hFFF_FFFF));
    queue_random(RANDOM_PER_PHASE);
    drain();

    if (!failed) begin
      $display("tb_fair_share_debt_limiter passed");
    end else begin
      $display("tb_fair_share_debt_limiter failed");
    end
    $finish;
  end

endmodule
`default_nettype wire
